/* rtl/gclu_pkg.sv */
// ============================================================================
// gclu_pkg: shared types and constants for the divisor and multiple unit
// Holds the state encoding, the operation codes and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package gclu_pkg;

    localparam int FIELD_W  = 16;
    localparam int RESULT_W = 32;

    typedef enum logic {
        OP_GCD = 1'b0,
        OP_LCM = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul;
        logic store;
    } t_dp_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_last;
        t_op  op;
    } t_dp_status;

endpackage

/* rtl/gclu_datapath.sv */
// ============================================================================
// gclu_datapath: operand registers, binary divisor search, divider, multiplier
// Runs one binary GCD step per cycle; for a multiple, a restoring division of
// the first operand by the divisor, one quotient bit per cycle, and one multiply.
// ============================================================================
module gclu_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                i_clk,
    input  gclu_pkg::t_dp_cmd                   i_cmd,
    output gclu_pkg::t_dp_status                o_status,
    input  gclu_pkg::t_op                       i_op,
    input  logic [gclu_pkg::FIELD_W-1:0]        i_first_operand,
    input  logic [gclu_pkg::FIELD_W-1:0]        i_second_operand,
    output logic [gclu_pkg::RESULT_W-1:0]       o_result_value
);
    import gclu_pkg::*;

    localparam int W  = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;
    localparam int KW = $clog2(W);

    t_op              r_op;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_u;
    logic [W-1:0]     r_v;
    logic [KW-1:0]    r_k;
    logic [W-1:0]     r_g;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [KW-1:0]    r_cnt;
    logic [2*W-1:0]   r_prod;
    logic [RESULT_W-1:0] r_result;

    logic [W-1:0]     w_first;
    logic [W-1:0]     w_second;
    logic [W-1:0]     w_g;
    logic [W-1:0]     w_diff_uv;
    logic [W-1:0]     w_diff_vu;
    logic [W:0]       w_rem_shift;
    logic [W:0]       w_rem_sub;
    logic             w_fits;

    assign w_first     = i_first_operand[W-1:0];
    assign w_second    = i_second_operand[W-1:0];
    assign w_g         = r_u << r_k;
    assign w_diff_uv   = r_u - r_v;
    assign w_diff_vu   = r_v - r_u;
    assign w_rem_shift = {r_rem, r_quo[W-1]};
    assign w_rem_sub   = w_rem_shift - {1'b0, r_g};
    assign w_fits      = (w_rem_shift >= {1'b0, r_g});

    // Binary GCD: a zero operand is replaced by a divisor of one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_a  <= w_first;
            r_b  <= w_second;
            r_k  <= '0;
            if ((w_first == '0) || (w_second == '0)) begin
                r_u <= W'(1);
                r_v <= W'(1);
            end else begin
                r_u <= w_first;
                r_v <= w_second;
            end
        end else if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= w_diff_uv >> 1;
            end else begin
                r_v <= w_diff_vu >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_g   <= w_g;
            r_rem <= '0;
            r_quo <= r_a;
            r_cnt <= KW'(W - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= w_fits ? w_rem_sub[W-1:0] : w_rem_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], w_fits};
            r_cnt <= r_cnt - KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_quo * r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            if (r_op == OP_GCD) begin
                r_result <= RESULT_W'(w_g);
            end else begin
                r_result <= RESULT_W'(r_prod);
            end
        end
    end

    assign o_status.gcd_done = (r_u == r_v);
    assign o_status.div_last = (r_cnt == '0);
    assign o_status.op       = r_op;
    assign o_result_value    = r_result;

endmodule

/* rtl/gclu_ctrl.sv */
// ============================================================================
// gclu_ctrl: sequencing state machine and output valid flag
// Accepts an item when idle, runs the divisor search and, for a multiple,
// the division and the multiply, and hands the result to the output register.
// ============================================================================
module gclu_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  gclu_pkg::t_dp_status  i_status,
    output gclu_pkg::t_dp_cmd     o_cmd
);
    import gclu_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GCD;
                end
            end
            S_GCD: begin
                if (!i_status.gcd_done) begin
                    o_cmd.gcd_step = 1'b1;
                end else if (i_status.op == OP_GCD) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.store = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/gcd_lcm_unit_top.sv */
// ============================================================================
// gcd_lcm_unit_top: greatest common divisor and least common multiple
// Each item carries an operation and two unsigned operands and yields one
// result: the greatest common divisor (operation 0) or the least common
// multiple (operation 1). A zero operand gives a divisor of one and a
// multiple of zero. One item is in work at a time. After acceptance the
// divisor is found by binary GCD steps; a multiple then adds a restoring
// division of the first operand by the divisor and a multiply before the
// result is valid. The unit is ready for the next item in the cycle after
// the result is stored. The finished result sits in an output register, so
// the next item is taken while it waits to be collected.
// ============================================================================
module gcd_lcm_unit_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] first_operand, [31:16] second_operand
    input  logic [2*gclu_pkg::FIELD_W-1:0]    i_s_axis_tdata,
    // [0] operation
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] result_value
    output logic [gclu_pkg::RESULT_W-1:0]     o_m_axis_tdata
);
    import gclu_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_op        w_op;

    assign w_op = t_op'(i_s_axis_tuser);

    gclu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gclu_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_op             (w_op),
        .i_first_operand  (i_s_axis_tdata[FIELD_W-1:0]),
        .i_second_operand (i_s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .o_result_value   (o_m_axis_tdata)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("item accepted while another is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.store |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("pending result overwritten");

    a_store_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.store |=> (o_m_axis_tvalid && o_s_axis_tready))
        else $error("stored result not presented");

endmodule
